@@ rtl/palette_to_premultiplied_rgba_assert.svh @@
// Assertion macros shared by the palette converter RTL.
// Each macro checks on the rising edge of clk and is disabled during rst.
`ifndef PALETTE_TO_PREMULTIPLIED_RGBA_ASSERT_SVH
`define PALETTE_TO_PREMULTIPLIED_RGBA_ASSERT_SVH
`ifndef ASSERT_OFF
`define PTPR_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("palette converter assertion failed");
`define PTPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("palette converter assertion failed");
`else
`define PTPR_ASSERT(label, ante, cons)
`define PTPR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/ptpr_pkg.sv @@
package ptpr_pkg;

  // Command codes carried in the command field of an input beat.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // Register map, as word indexes.
  localparam logic REG_COLOR_COUNT = 1'b0;

  localparam int unsigned COUNT_W = 9;
  localparam logic [COUNT_W-1:0] COLOR_COUNT_RESET = 9'd256;

  localparam logic [15:0] ROUND_BIAS = 16'd127;

  typedef struct packed {
    logic        command;
    logic [7:0]  slot;
    logic [31:0] color;
    logic [7:0]  pixel_index;
  } cmd_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // (p + 127) / 255 for p up to 255 * 255, without a divider.
  // With y = p + 128, (y - 1) / 255 equals (y + (y >> 8)) >> 8 over this range.
  function automatic logic [7:0] div255_round(input logic [15:0] p);
    logic [15:0] x;
    logic [16:0] y;
    logic [17:0] s;
    x = p + ROUND_BIAS;
    y = {1'b0, x} + 17'd1;
    s = {1'b0, y} + 18'(y >> 8);
    return s[15:8];
  endfunction

endpackage

@@ rtl/ptpr_ram.sv @@
module ptpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // Read data holds while re is low.
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/palette_to_premultiplied_rgba.sv @@
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------
// cmd      | in        | cmd_valid / cmd_ready  | ptpr_pkg::cmd_t (load or pixel)
// px       | out       | px_valid / px_ready    | ptpr_pkg::rgba_t (premult RGBA)
// apb      | in        | psel, penable, pwrite  | color_count at byte address 0
//
// One command beat is taken per cycle while cmd_ready is high; a pixel passes
// through palette read, multiply, divide by 255 into the output register.
// Loads write the palette at the edge they are accepted and make no result.
// rst is synchronous, clears the stage valid bits and sets color_count to 256;
// the palette itself has no reset and holds whatever was loaded.
// A stall on px backs up through the stages one at a time; cmd_ready drops
// only when every stage holds a pixel and px_ready is low.
module palette_to_premultiplied_rgba #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic            clk,
  input  logic            rst,

  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  ptpr_pkg::cmd_t  cmd,

  output logic            px_valid,
  input  logic            px_ready,
  output ptpr_pkg::rgba_t px,

  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int ADDR_W = $clog2(PALETTE_DEPTH);
  localparam logic [ptpr_pkg::COUNT_W-1:0] DEPTH_LIMIT =
    ptpr_pkg::COUNT_W'(PALETTE_DEPTH);

  // ---------------------------------------------------------------------------
  // Configuration register. Writes complete in the access phase; pready is
  // tied high so no wait states are ever inserted.
  // ---------------------------------------------------------------------------
  logic [ptpr_pkg::COUNT_W-1:0] color_count;
  logic                         cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_count <= ptpr_pkg::COLOR_COUNT_RESET;
    end else if (cfg_write && paddr[2] == ptpr_pkg::REG_COLOR_COUNT) begin
      color_count <= pwdata[ptpr_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == ptpr_pkg::REG_COLOR_COUNT) begin
      prdata = {{(32 - ptpr_pkg::COUNT_W){1'b0}}, color_count};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage handshakes. Each stage takes new data when it is empty or when the
  // stage after it is moving, so bubbles are squeezed out during a stall.
  // ---------------------------------------------------------------------------
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  logic cmd_fire;
  logic is_pixel;
  logic is_load;

  assign rdy3      = !v3 || px_ready;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign cmd_ready = rdy1;
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign is_pixel  = cmd.command == ptpr_pkg::CMD_PIXEL;
  assign is_load   = cmd.command == ptpr_pkg::CMD_LOAD;

  // ---------------------------------------------------------------------------
  // Stage 1: palette access. A load writes at its accept edge, so a pixel in
  // the very next beat already reads the new entry. Slots beyond the palette
  // are dropped. The read register only updates on an accepted pixel, which
  // keeps stage 1 data steady while the pipeline is stalled.
  // ---------------------------------------------------------------------------
  logic              ram_we;
  logic              ram_re;
  logic [31:0]       ram_rdata;
  logic              in_range1;
  logic              idx_ok;

  assign ram_we = cmd_fire && is_load &&
                  ({1'b0, cmd.slot} < DEPTH_LIMIT);
  assign ram_re = cmd_fire && is_pixel;
  assign idx_ok = ({1'b0, cmd.pixel_index} < color_count) &&
                  ({1'b0, cmd.pixel_index} < DEPTH_LIMIT);

  ptpr_ram #(
    .WIDTH (32),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd.slot[ADDR_W-1:0]),
    .wdata (cmd.color),
    .re    (ram_re),
    .raddr (cmd.pixel_index[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      in_range1 <= idx_ok;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: out-of-range indexes become transparent black, then each color
  // channel is multiplied by alpha.
  // ---------------------------------------------------------------------------
  logic [31:0] argb1;
  logic [15:0] prod_r, prod_g, prod_b;
  logic [7:0]  alpha2;

  assign argb1 = in_range1 ? ram_rdata : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      prod_r <= 16'(argb1[23:16]) * 16'(argb1[31:24]);
      prod_g <= 16'(argb1[15:8])  * 16'(argb1[31:24]);
      prod_b <= 16'(argb1[7:0])   * 16'(argb1[31:24]);
      alpha2 <= argb1[31:24];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: rounded divide by 255 into the output register.
  // ---------------------------------------------------------------------------
  ptpr_pkg::rgba_t px_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      px_q.red   <= ptpr_pkg::div255_round(prod_r);
      px_q.green <= ptpr_pkg::div255_round(prod_g);
      px_q.blue  <= ptpr_pkg::div255_round(prod_b);
      px_q.alpha <= alpha2;
    end
  end

  assign px_valid = v3;
  assign px       = px_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
`include "palette_to_premultiplied_rgba_assert.svh"

  // An accepted pixel always occupies stage 1 on the next cycle.
  `PTPR_ASSERT_NEXT(a_pixel_enters, cmd_fire && is_pixel, v1)
  // An accepted load never creates a result.
  `PTPR_ASSERT_NEXT(a_load_no_result, cmd_fire && is_load, !v1)
  // Zero alpha must give transparent black after premultiplication.
  `PTPR_ASSERT(a_zero_alpha_black, px_valid && px.alpha == '0, {px.red, px.green, px.blue} == '0)

endmodule
